// ----- rtl/core/opdcs_pkg.sv -----
// ----------------------------------------------------------------------------
// opdcs_pkg
// Shared types and constants of the open-page command sequencer.
// ----------------------------------------------------------------------------
package opdcs_pkg;

    localparam int DEF_BANK_COUNT  = 4;
    localparam int DEF_COLUMN_BITS = 5;
    localparam int DEF_BANK_BITS   = 2;

    localparam int FIFO_DEPTH = 4;

    localparam int ADDR_W  = 16;
    localparam int LEN_W   = 8;
    localparam int CODE_W  = 3;
    localparam int ROC_W   = 9;
    localparam int BIDX_W  = 2;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_PRECHARGE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ACTIVATE  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_READ      = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_WRITE     = 2'd3;

    localparam logic [CODE_W-1:0] RST_PRECHARGE_CODE = 3'd0;
    localparam logic [CODE_W-1:0] RST_ACTIVATE_CODE  = 3'd1;
    localparam logic [CODE_W-1:0] RST_READ_CODE      = 3'd2;
    localparam logic [CODE_W-1:0] RST_WRITE_CODE     = 3'd3;

    // Row state of the target bank at classification time.
    typedef enum logic [1:0] {
        KIND_HIT  = 2'd0,   // row already open: column command only
        KIND_OPEN = 2'd1,   // bank idle: activate, column
        KIND_SWAP = 2'd2    // other row open: precharge, activate, column
    } kind_t;

    typedef enum logic [1:0] {
        ST_START = 2'd0,
        ST_ACT   = 2'd1,
        ST_COL   = 2'd2
    } step_t;

    typedef struct packed {
        kind_t              kind;
        logic               is_write;
        logic [BIDX_W-1:0]  bank;
        logic [ROC_W-1:0]   row;
        logic [ROC_W-1:0]   column;
        logic [LEN_W-1:0]   length;
    } req_t;

    typedef struct packed {
        logic full;
        logic valid;
    } fifo_status_t;

endpackage

// ----- rtl/core/opdcs_fifo.sv -----
// ----------------------------------------------------------------------------
// opdcs_fifo
// Short request queue between the classifier and the command issuer.
// ----------------------------------------------------------------------------
module opdcs_fifo
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  opdcs_pkg::req_t       push_entry,
    input  logic                  pop,
    output opdcs_pkg::req_t       head_entry,
    output opdcs_pkg::fifo_status_t status
);

    localparam int DEPTH = opdcs_pkg::FIFO_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    opdcs_pkg::req_t   mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_entry   = mem[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.valid = (count_reg != '0);

endmodule

// ----- rtl/core/opdcs_front.sv -----
// ----------------------------------------------------------------------------
// opdcs_front
// Request intake: splits the address, tracks open rows, classifies the item.
// ----------------------------------------------------------------------------
module opdcs_front
#(
    parameter int BANK_COUNT  = opdcs_pkg::DEF_BANK_COUNT,
    parameter int COLUMN_BITS = opdcs_pkg::DEF_COLUMN_BITS,
    parameter int BANK_BITS   = opdcs_pkg::DEF_BANK_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // word_address, write_length
    input  logic                          s_tuser,   // mode
    input  opdcs_pkg::fifo_status_t       status,
    output logic                          push,
    output opdcs_pkg::req_t               push_entry
);

    localparam int IDX_W   = (BANK_COUNT > 2) ? $clog2(BANK_COUNT) : 1;
    localparam int ROW_LSB = COLUMN_BITS + BANK_BITS;
    localparam int ADDR_W  = opdcs_pkg::ADDR_W;
    localparam int ROC_W   = opdcs_pkg::ROC_W;

    logic [ADDR_W-1:0]     word_address;
    logic [ADDR_W-1:0]     col_full;
    logic [ADDR_W-1:0]     bank_shift;
    logic [ADDR_W-1:0]     row_full;
    logic [BANK_BITS-1:0]  bank_raw;
    logic [4:0]            bank_mod;
    logic [IDX_W-1:0]      bank_idx;
    logic [ROC_W-1:0]      row;
    logic                  row_hit;
    logic                  accept;

    logic [ROC_W-1:0]      open_row_reg [BANK_COUNT];
    logic [BANK_COUNT-1:0] row_open_reg;
    logic [BANK_COUNT-1:0] row_open_next;

    assign word_address = s_tdata[15:0];
    assign col_full     = word_address & ADDR_W'((32'd1 << COLUMN_BITS) - 32'd1);
    assign bank_shift   = word_address >> COLUMN_BITS;
    assign bank_raw     = bank_shift[BANK_BITS-1:0];
    assign row_full     = word_address >> ROW_LSB;
    assign row          = row_full[ROC_W-1:0];

    // Reduce bank modulo the bank count.
    always_comb
    begin
        bank_mod = 5'(bank_raw);
        for (int i = 0; i < 8; i++)
        begin
            if (bank_mod >= 5'(BANK_COUNT))
            begin
                bank_mod = bank_mod - 5'(BANK_COUNT);
            end
        end
    end

    assign bank_idx = IDX_W'(bank_mod);
    assign row_hit  = row_open_reg[bank_idx] && (open_row_reg[bank_idx] == row);
    assign s_tready = !status.full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept;

    always_comb
    begin
        push_entry.is_write = s_tuser;
        push_entry.bank     = opdcs_pkg::BIDX_W'(bank_mod);
        push_entry.row      = row;
        push_entry.column   = col_full[ROC_W-1:0];
        push_entry.length   = s_tdata[23:16];
        if (row_hit)
        begin
            push_entry.kind = opdcs_pkg::KIND_HIT;
        end
        else if (row_open_reg[bank_idx])
        begin
            push_entry.kind = opdcs_pkg::KIND_SWAP;
        end
        else
        begin
            push_entry.kind = opdcs_pkg::KIND_OPEN;
        end
    end

    always_comb
    begin
        row_open_next = row_open_reg;
        if (accept)
        begin
            row_open_next[bank_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_open_reg <= '0;
        end
        else
        begin
            row_open_reg <= row_open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !row_hit)
        begin
            open_row_reg[bank_idx] <= row;
        end
    end

endmodule

// ----- rtl/core/opdcs_back.sv -----
// ----------------------------------------------------------------------------
// opdcs_back
// Command issuer: expands each queued request into its command items.
// ----------------------------------------------------------------------------
module opdcs_back
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [opdcs_pkg::REG_IDX_W-1:0]        cfg_index,
    input  logic [opdcs_pkg::CODE_W-1:0]           cfg_data,
    input  opdcs_pkg::fifo_status_t                status,
    input  opdcs_pkg::req_t                        head_entry,
    output logic                                   pop,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [23:0]                            m_tdata,  // bank_index, row_or_column, data_length
    output logic [opdcs_pkg::CODE_W-1:0]           m_tuser,  // command_code
    output logic                                   m_tlast
);

    localparam int CODE_W = opdcs_pkg::CODE_W;
    localparam int ROC_W  = opdcs_pkg::ROC_W;
    localparam int LEN_W  = opdcs_pkg::LEN_W;
    localparam int BIDX_W = opdcs_pkg::BIDX_W;

    logic [CODE_W-1:0]  code_reg [4];

    opdcs_pkg::step_t   step_reg;
    opdcs_pkg::step_t   step_next;
    logic               advance;

    logic [CODE_W-1:0]  cmd_code;
    logic [ROC_W-1:0]   cmd_roc;
    logic [LEN_W-1:0]   cmd_len;
    logic               cmd_last;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [CODE_W-1:0]  out_code_reg;
    logic [BIDX_W-1:0]  out_bank_reg;
    logic [ROC_W-1:0]   out_roc_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic               out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg[opdcs_pkg::REG_PRECHARGE] <= opdcs_pkg::RST_PRECHARGE_CODE;
            code_reg[opdcs_pkg::REG_ACTIVATE]  <= opdcs_pkg::RST_ACTIVATE_CODE;
            code_reg[opdcs_pkg::REG_READ]      <= opdcs_pkg::RST_READ_CODE;
            code_reg[opdcs_pkg::REG_WRITE]     <= opdcs_pkg::RST_WRITE_CODE;
        end
        else if (cfg_wr_en)
        begin
            code_reg[cfg_index] <= cfg_data;
        end
    end

    assign advance = status.valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        step_next = step_reg;
        if (advance)
        begin
            case (step_reg)
                opdcs_pkg::ST_START:
                begin
                    case (head_entry.kind)
                        opdcs_pkg::KIND_SWAP: step_next = opdcs_pkg::ST_ACT;
                        opdcs_pkg::KIND_OPEN: step_next = opdcs_pkg::ST_COL;
                        default:              step_next = opdcs_pkg::ST_START;
                    endcase
                end
                opdcs_pkg::ST_ACT: step_next = opdcs_pkg::ST_COL;
                default:           step_next = opdcs_pkg::ST_START;
            endcase
        end
    end

    // Pick the command for the current step of the head request.
    always_comb
    begin
        cmd_code = head_entry.is_write ? code_reg[opdcs_pkg::REG_WRITE]
                                       : code_reg[opdcs_pkg::REG_READ];
        cmd_roc  = head_entry.column;
        cmd_len  = head_entry.is_write ? head_entry.length : '0;
        cmd_last = 1'b1;
        case (step_reg)
            opdcs_pkg::ST_START:
            begin
                case (head_entry.kind)
                    opdcs_pkg::KIND_SWAP:
                    begin
                        cmd_code = code_reg[opdcs_pkg::REG_PRECHARGE];
                        cmd_roc  = head_entry.row;
                        cmd_len  = '0;
                        cmd_last = 1'b0;
                    end
                    opdcs_pkg::KIND_OPEN:
                    begin
                        cmd_code = code_reg[opdcs_pkg::REG_ACTIVATE];
                        cmd_roc  = head_entry.row;
                        cmd_len  = '0;
                        cmd_last = 1'b0;
                    end
                    default:
                    begin
                        cmd_last = 1'b1;
                    end
                endcase
            end
            opdcs_pkg::ST_ACT:
            begin
                cmd_code = code_reg[opdcs_pkg::REG_ACTIVATE];
                cmd_roc  = head_entry.row;
                cmd_len  = '0;
                cmd_last = 1'b0;
            end
            default:
            begin
                cmd_last = 1'b1;
            end
        endcase
    end

    assign pop = advance && cmd_last;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= opdcs_pkg::ST_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_code_reg <= cmd_code;
            out_bank_reg <= head_entry.bank;
            out_roc_reg  <= cmd_roc;
            out_len_reg  <= cmd_len;
            out_last_reg <= cmd_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_code_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'b0, out_len_reg, out_roc_reg, out_bank_reg};

endmodule

// ----- rtl/core/open_page_dram_command_sequencer.sv -----
// ----------------------------------------------------------------------------
// open_page_dram_command_sequencer
// Turns read/write requests into precharge, activate and column commands.
//
//   channel   dir  handshake           content
//   s_*       in   s_tvalid/s_tready   request: address, length, mode
//   m_*       out  m_tvalid/m_tready   command: bank, row/column, length, code
//   cfg_*     in   cfg_wr_en           command code registers
//
// One command item leaves per cycle while m_tready is high; a request expands
// into one to three items (row hit, idle bank, row conflict) through the single command output register.
// The four-entry request queue lets intake run ahead of the command output.
// Reset closes all rows and restores default codes; no clearing pass.
// A stalled output holds its item while the queue keeps taking requests until full.
// ----------------------------------------------------------------------------
module open_page_dram_command_sequencer
#(
    parameter int BANK_COUNT  = opdcs_pkg::DEF_BANK_COUNT,
    parameter int COLUMN_BITS = opdcs_pkg::DEF_COLUMN_BITS,
    parameter int BANK_BITS   = opdcs_pkg::DEF_BANK_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // word_address, write_length
    input  logic                              s_tuser,   // mode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,   // bank_index, row_or_column, data_length
    output logic [opdcs_pkg::CODE_W-1:0]      m_tuser,   // command_code
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [opdcs_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [opdcs_pkg::CODE_W-1:0]      cfg_data
);

    logic                     push;
    logic                     pop;
    opdcs_pkg::req_t          push_entry;
    opdcs_pkg::req_t          head_entry;
    opdcs_pkg::fifo_status_t  status;

    opdcs_front
    #(
        .BANK_COUNT  (BANK_COUNT),
        .COLUMN_BITS (COLUMN_BITS),
        .BANK_BITS   (BANK_BITS)
    )
    u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .status     (status),
        .push       (push),
        .push_entry (push_entry)
    );

    opdcs_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .status     (status)
    );

    opdcs_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .status     (status),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ----- tb/tb_open_page_dram_command_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_open_page_dram_command_sequencer
// Self-checking bench for the open-page command sequencer. Requests go in on
// the slave stream; a local copy of the per-bank open-row state predicts the
// precharge, activate and column commands, which are checked in order as they
// leave the master stream. Covers row hit, idle bank and row conflict, all
// four code registers at their extremes, long output back-pressure and
// random requests with row locality under random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_open_page_dram_command_sequencer;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 60000;
    localparam int RANDOM_ITEMS = 60;
    localparam int COL_BITS     = opdcs_pkg::DEF_COLUMN_BITS;
    localparam int BANKS        = opdcs_pkg::DEF_BANK_COUNT;
    localparam int CODE_W       = opdcs_pkg::CODE_W;
    localparam int BIDX_W       = opdcs_pkg::BIDX_W;
    localparam int ROC_W        = opdcs_pkg::ROC_W;
    localparam int LEN_W        = opdcs_pkg::LEN_W;
    localparam int ADDR_W       = opdcs_pkg::ADDR_W;
    localparam int REG_IDX_W    = opdcs_pkg::REG_IDX_W;
    localparam int EXP_DEPTH    = 1024;
    localparam int EXP_PTR_W    = 10;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [BIDX_W-1:0] bank;
        logic [ROC_W-1:0]  roc;
        logic [LEN_W-1:0]  len;
        logic              last;
    } dram_cmd_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata = '0;    // word_address, write_length
    logic                 s_tuser = 1'b0;  // mode
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;         // bank_index, row_or_column, data_length
    logic [CODE_W-1:0]    m_tuser;         // command_code
    logic                 m_tlast;
    logic                 cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [CODE_W-1:0]    cfg_data = '0;

    // local copy of the sequencer state
    logic [CODE_W-1:0] cmd_codes [4];
    logic [ROC_W-1:0]  open_row [BANKS];
    bit                row_is_open [BANKS];

    dram_cmd_t expected_cmds [EXP_DEPTH];
    int        exp_wr_count = 0;
    int        exp_rd_count = 0;
    int        error_count = 0;
    int        hold_cycles = 0;
    bit        steady = 1'b0;

    open_page_dram_command_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int pending_count();
        return exp_wr_count - exp_rd_count;
    endfunction

    function automatic void push_cmd(input logic [CODE_W-1:0] code,
                                     input logic [BIDX_W-1:0] bank,
                                     input logic [ROC_W-1:0] roc,
                                     input logic [LEN_W-1:0] len, input logic last);
        dram_cmd_t cmd;
        cmd.code = code;
        cmd.bank = bank;
        cmd.roc  = roc;
        cmd.len  = len;
        cmd.last = last;
        expected_cmds[EXP_PTR_W'(exp_wr_count)] = cmd;
        exp_wr_count++;
    endfunction

    // expected commands of one accepted request
    function automatic void predict_commands(input logic wr, input logic [ADDR_W-1:0] addr,
                                             input logic [LEN_W-1:0] len);
        logic [ROC_W-1:0]  column;
        logic [BIDX_W-1:0] bank;
        logic [ROC_W-1:0]  row;
        column = ROC_W'(addr[COL_BITS-1:0]);
        bank   = addr[COL_BITS +: BIDX_W];
        row    = ROC_W'(addr >> (COL_BITS + BIDX_W));
        if (!row_is_open[bank] || open_row[bank] != row)
        begin
            if (row_is_open[bank])
                push_cmd(cmd_codes[opdcs_pkg::REG_PRECHARGE], bank, row, '0, 1'b0);
            push_cmd(cmd_codes[opdcs_pkg::REG_ACTIVATE], bank, row, '0, 1'b0);
            open_row[bank]    = row;
            row_is_open[bank] = 1'b1;
        end
        if (wr)
            push_cmd(cmd_codes[opdcs_pkg::REG_WRITE], bank, column, len, 1'b1);
        else
            push_cmd(cmd_codes[opdcs_pkg::REG_READ], bank, column, '0, 1'b1);
    endfunction

    function automatic void compare_field(input string name, input int exp_val,
                                          input int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            error_count++;
        end
    endfunction

    function automatic void check_command();
        dram_cmd_t exp_cmd;
        if (pending_count() == 0)
        begin
            $display("%0t: unexpected command, expected none, actual code %0d tdata %h",
                     $time, m_tuser, m_tdata);
            error_count++;
            return;
        end
        exp_cmd = expected_cmds[EXP_PTR_W'(exp_rd_count)];
        exp_rd_count++;
        compare_field("command_code", int'(exp_cmd.code), int'(m_tuser));
        compare_field("bank_index", int'(exp_cmd.bank), int'(m_tdata[1:0]));
        compare_field("row_or_column", int'(exp_cmd.roc), int'(m_tdata[10:2]));
        compare_field("data_length", int'(exp_cmd.len), int'(m_tdata[18:11]));
        compare_field("last", int'(exp_cmd.last), int'(m_tlast));
    endfunction

    // command receiver and checker
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                check_command();
                stall = steady ? 0 : int'($urandom_range(0, 4));
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_request(input logic wr, input logic [ADDR_W-1:0] addr,
                                input logic [LEN_W-1:0] len);
        int gap;
        gap = steady ? 0 : int'($urandom_range(0, 4));
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, addr};
        s_tuser  <= wr;
        do @(posedge clk); while (!s_tready);
        predict_commands(wr, addr, len);
    endtask

    // half the time hit the open row of an open bank, otherwise a new or a corner row
    task automatic send_random_request();
        logic [BIDX_W-1:0]   bank;
        logic [ROC_W-1:0]    row;
        logic [COL_BITS-1:0] column;
        int                  pick;
        bank   = BIDX_W'($urandom_range(0, BANKS - 1));
        column = COL_BITS'($urandom);
        pick   = int'($urandom_range(0, 9));
        if (pick < 5 && row_is_open[bank])
            row = open_row[bank];
        else if (pick < 7)
            row = ($urandom_range(0, 1) == 0) ? '0 : '1;
        else
            row = ROC_W'($urandom);
        send_request(1'($urandom_range(0, 1)), {row, bank, column}, LEN_W'($urandom));
    endtask

    task automatic drain_commands();
        s_tvalid <= 1'b0;
        while (pending_count() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_code_reg(input logic [REG_IDX_W-1:0] idx,
                                  input logic [CODE_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cmd_codes[idx] = val;
    endtask

    task automatic write_codes(input logic [CODE_W-1:0] pre, act, rd, wr);
        write_code_reg(opdcs_pkg::REG_PRECHARGE, pre);
        write_code_reg(opdcs_pkg::REG_ACTIVATE, act);
        write_code_reg(opdcs_pkg::REG_READ, rd);
        write_code_reg(opdcs_pkg::REG_WRITE, wr);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_default_codes();
        send_request(1'b0, 16'h0000, 8'h00);   // idle bank
        send_request(1'b0, 16'h0000, 8'hff);   // row hit, length ignored on read
        send_request(1'b1, 16'h001f, 8'hff);   // hit, top column
        send_request(1'b0, 16'hff80, 8'h00);   // conflict, top row
        send_request(1'b1, 16'hffff, 8'h00);   // bank 3 idle, zero length
        send_request(1'b0, 16'h0060, 8'h12);   // bank 3 conflict back to row 0
        send_request(1'b1, 16'h0020, 8'ha5);
        send_request(1'b1, 16'h0040, 8'h5a);
        send_request(1'b0, 16'haaaa, 8'h55);
        send_request(1'b1, 16'h5555, 8'haa);
        send_request(1'b1, 16'h5555, 8'h01);   // hit after conflict
        drain_commands();
    endtask

    task automatic test_code_registers();
        write_codes(3'd7, 3'd7, 3'd7, 3'd7);
        send_request(1'b0, 16'h0080, 8'h00);
        send_request(1'b1, 16'h0081, 8'h80);
        drain_commands();
        write_codes(3'd0, 3'd0, 3'd0, 3'd0);
        send_request(1'b1, 16'h3fa0, 8'h7f);
        send_request(1'b0, 16'h3fbe, 8'h00);
        drain_commands();
        write_codes(3'd5, 3'd6, 3'd4, 3'd7);
        send_request(1'b1, 16'h8040, 8'hfe);
        send_request(1'b0, 16'h0040, 8'h00);
        send_request(1'b1, 16'h0041, 8'h33);
        drain_commands();
    endtask

    task automatic test_backpressure();
        steady      = 1'b1;
        hold_cycles = 60;
        repeat (16) send_random_request();
        steady = 1'b0;
        drain_commands();
    endtask

    task automatic test_random_requests();
        for (int seg = 0; seg < 4; seg++)
        begin
            write_codes(CODE_W'($urandom), CODE_W'($urandom),
                        CODE_W'($urandom), CODE_W'($urandom));
            steady = (seg == 2);
            repeat (RANDOM_ITEMS / 4) send_random_request();
            steady = 1'b0;
            drain_commands();
        end
        write_codes(opdcs_pkg::RST_PRECHARGE_CODE, opdcs_pkg::RST_ACTIVATE_CODE,
                    opdcs_pkg::RST_READ_CODE, opdcs_pkg::RST_WRITE_CODE);
        repeat (10) send_random_request();
        drain_commands();
    endtask

    initial
    begin
        cmd_codes[opdcs_pkg::REG_PRECHARGE] = opdcs_pkg::RST_PRECHARGE_CODE;
        cmd_codes[opdcs_pkg::REG_ACTIVATE]  = opdcs_pkg::RST_ACTIVATE_CODE;
        cmd_codes[opdcs_pkg::REG_READ]      = opdcs_pkg::RST_READ_CODE;
        cmd_codes[opdcs_pkg::REG_WRITE]     = opdcs_pkg::RST_WRITE_CODE;
        for (int b = 0; b < BANKS; b++)
        begin
            open_row[b]    = '0;
            row_is_open[b] = 1'b0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_codes();
        test_code_registers();
        test_backpressure();
        test_random_requests();

        repeat (10) @(posedge clk);
        if (error_count == 0 && pending_count() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
